// ===== sv/psd_pkg.sv =====
// Shared types and constants for the Prufer sequence decoder.
`default_nettype none
package psd_pkg;
   localparam int FIELD_W = 13;
   localparam int DEFAULT_MAX_NODES = 4096;
   localparam logic [FIELD_W-1:0] NODE_COUNT_RESET = 13'd2;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_RANGE = 2'd1,
      ERR_PHASE = 2'd2
   } error_type;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_EDGE = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      HOP_NONE,
      HOP_PUSH,
      HOP_POP,
      HOP_CLR
   } heap_op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILL,
      ST_CODE,
      ST_POS,
      ST_EDGE,
      ST_PUSH,
      ST_OUT
   } state_type;
endpackage
`default_nettype wire

// ===== sv/psd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module psd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== sv/psd_cell.sv =====
// One cell of the sorted leaf queue: holds one key and trades it with its neighbors.
`default_nettype none
module psd_cell #(
   parameter int KEY_W = 12
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire psd_pkg::heap_op_type      op,
   input  wire logic [KEY_W-1:0]          key,
   input  wire logic                      left_less,
   input  wire logic [KEY_W-1:0]          left_val,
   input  wire logic                      left_vld,
   input  wire logic [KEY_W-1:0]          right_val,
   input  wire logic                      right_vld,
   output logic      [KEY_W-1:0]          val,
   output logic                           vld,
   output logic                           less
);
   import psd_pkg::*;

   logic [KEY_W-1:0] val_ff;
   logic [KEY_W-1:0] val_in;
   logic             vld_ff;
   logic             vld_in;

   assign less = vld_ff && (val_ff < key);

   always_comb begin
      val_in = val_ff;
      vld_in = vld_ff;
      case (op)
         HOP_PUSH: begin
            if (!less) begin
               if (left_less) begin
                  val_in = key;
                  vld_in = 1'b1;
               end else begin
                  val_in = left_val;
                  vld_in = left_vld;
               end
            end
         end
         HOP_POP: begin
            val_in = right_val;
            vld_in = right_vld;
         end
         HOP_CLR: begin
            vld_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      val_ff <= val_in;
   end

   assign val = val_ff;
   assign vld = vld_ff;
endmodule
`default_nettype wire

// ===== sv/psd_heap.sv =====
// Sorted chain of cells that serves as the leaf priority queue.
`default_nettype none
module psd_heap #(
   parameter int KEY_W = 12,
   parameter int DEPTH = 4096
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire psd_pkg::heap_op_type op,
   input  wire logic [KEY_W-1:0]     key,
   output logic      [KEY_W-1:0]     min0,
   output logic      [KEY_W-1:0]     min1
);
   import psd_pkg::*;

   logic [KEY_W-1:0] val  [DEPTH];
   logic             vld  [DEPTH];
   logic             less [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic             l_less;
      logic [KEY_W-1:0] l_val;
      logic             l_vld;
      logic [KEY_W-1:0] r_val;
      logic             r_vld;
      if (i == 0) begin : g_first
         assign l_less = 1'b1;
         assign l_val  = key;
         assign l_vld  = 1'b0;
      end else begin : g_mid
         assign l_less = less[i-1];
         assign l_val  = val[i-1];
         assign l_vld  = vld[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign r_val = key;
         assign r_vld = 1'b0;
      end else begin : g_inner
         assign r_val = val[i+1];
         assign r_vld = vld[i+1];
      end
      psd_cell #(.KEY_W(KEY_W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .op        (op),
         .key       (key),
         .left_less (l_less),
         .left_val  (l_val),
         .left_vld  (l_vld),
         .right_val (r_val),
         .right_vld (r_vld),
         .val       (val[i]),
         .vld       (vld[i]),
         .less      (less[i])
      );
   end

   assign min0 = val[0];
   assign min1 = val[1];
endmodule
`default_nettype wire

// ===== sv/prufer_sequence_decoder.sv =====
// Top level of the Prufer sequence decoder.
//
//   port group   direction  role
//   req_*        in         code entry load or edge request word
//   rsp_*        out        edge or error word
//   csr_*        in         node count register write
//
// A good load is written into the tables in the cycle it is accepted. The
// first edge request scans all node entries before its edge. Each edge then
// steps through CODE, POS, EDGE, PUSH if a node becomes a leaf, and OUT; the
// last edge goes from CODE to OUT. The queue cells pop or push together. After
// reset the node table is cleared entry by entry while req_stall stays high.
// rsp_stall holds the result word; requests are still taken, but the next result waits in OUT.
`default_nettype none
module prufer_sequence_decoder #(
   parameter int MAX_NODES = psd_pkg::DEFAULT_MAX_NODES
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_cmd,
   input  wire logic [psd_pkg::FIELD_W-1:0] req_code_node,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic      [psd_pkg::FIELD_W-1:0] rsp_first_node,
   output logic      [psd_pkg::FIELD_W-1:0] rsp_second_node,
   output logic                             rsp_last_edge,
   output logic      [1:0]                  rsp_error,
   input  wire logic                        csr_wr_en,
   input  wire logic [psd_pkg::FIELD_W-1:0] csr_wr_data
);
   import psd_pkg::*;

   localparam int NW = $clog2(MAX_NODES);
   localparam int CW = $clog2(MAX_NODES + 1);
   localparam int CMPW = (CW > FIELD_W) ? CW : FIELD_W;
   localparam int LPW = CW + 1;

   state_type state_ff, state_in;

   logic [FIELD_W-1:0] node_count_ff;
   logic [CW-1:0]      load_count_ff, edge_count_ff, scan_ff;
   logic               draining_ff, pv_ff;
   logic [NW-1:0]      pa_ff, a_ff, clr_ff;
   logic [FIELD_W-1:0] h_first_ff, h_second_ff;
   logic               h_last_ff;
   error_type          h_err_ff;
   logic               rsp_valid_ff;
   logic [FIELD_W-1:0] rsp_first_ff, rsp_second_ff;
   logic               rsp_last_ff;
   error_type          rsp_err_ff;

   logic [CW-1:0]      n_eff, len;
   logic               accept, load_bad_phase, node_bad, edge_ready, fill_done;
   logic               edge_more, push_hit, scan_issue, out_free;
   logic [NW-1:0]      node_addr;
   logic [NW:0]        a_inc, min0_inc, min1_inc;

   logic               lp_we;
   logic [NW-1:0]      lp_waddr, lp_raddr;
   logic [LPW-1:0]     lp_wdata, lp_rdata;
   logic               cs_we;
   logic [NW-1:0]      cs_rdata;
   heap_op_type        h_op;
   logic [NW-1:0]      h_key, min0, min1;

   always_comb begin
      if (CMPW'(node_count_ff) < CMPW'(2)) begin
         n_eff = CW'(2);
      end else if (CMPW'(node_count_ff) > CMPW'(MAX_NODES)) begin
         n_eff = CW'(MAX_NODES);
      end else begin
         n_eff = CW'(node_count_ff);
      end
   end

   assign len            = n_eff - CW'(2);
   assign req_stall      = (state_ff != ST_IDLE);
   assign accept         = req_valid && !req_stall;
   assign load_bad_phase = draining_ff || (load_count_ff >= len);
   assign node_bad       = (req_code_node == '0) || (CMPW'(req_code_node) > CMPW'(n_eff));
   assign node_addr      = NW'(req_code_node - FIELD_W'(1));
   assign edge_ready     = (load_count_ff == len);
   assign scan_issue     = (scan_ff < n_eff);
   assign fill_done      = !scan_issue && !pv_ff;
   assign edge_more      = (edge_count_ff < len);
   assign push_hit       = lp_rdata[LPW-1] && (lp_rdata[CW-1:0] == edge_count_ff);
   assign out_free       = !rsp_valid_ff || !rsp_stall;
   assign a_inc          = {1'b0, a_ff} + (NW+1)'(1);
   assign min0_inc       = {1'b0, min0} + (NW+1)'(1);
   assign min1_inc       = {1'b0, min1} + (NW+1)'(1);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == NW'(MAX_NODES - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == CMD_LOAD) begin
                  if (load_bad_phase || node_bad) state_in = ST_OUT;
               end else if (draining_ff) begin
                  state_in = ST_CODE;
               end else begin
                  state_in = edge_ready ? ST_FILL : ST_OUT;
               end
            end
         end
         ST_FILL: if (fill_done) state_in = ST_CODE;
         ST_CODE: state_in = edge_more ? ST_POS : ST_OUT;
         ST_POS:  state_in = ST_EDGE;
         ST_EDGE: state_in = push_hit ? ST_PUSH : ST_OUT;
         ST_PUSH: state_in = ST_OUT;
         ST_OUT:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_CLEAR;
      endcase
   end

   // Memory and queue controls.
   always_comb begin
      lp_we    = 1'b0;
      lp_waddr = clr_ff;
      lp_wdata = '0;
      lp_raddr = scan_ff[NW-1:0];
      cs_we    = 1'b0;
      h_op     = HOP_NONE;
      h_key    = pa_ff;
      unique case (state_ff)
         ST_CLEAR: lp_we = 1'b1;
         ST_IDLE: begin
            if (accept && req_cmd == CMD_LOAD && !load_bad_phase && !node_bad) begin
               lp_we    = 1'b1;
               lp_waddr = node_addr;
               lp_wdata = {1'b1, load_count_ff};
               cs_we    = 1'b1;
            end
            if (accept && req_cmd == CMD_EDGE && !draining_ff && edge_ready) begin
               h_op = HOP_CLR;
            end
         end
         ST_FILL: begin
            if (pv_ff && !lp_rdata[LPW-1]) h_op = HOP_PUSH;
         end
         ST_CODE: if (!edge_more) h_op = HOP_CLR;
         ST_POS:  lp_raddr = cs_rdata;
         ST_EDGE: begin
            h_op = HOP_POP;
            if (push_hit) begin
               lp_we    = 1'b1;
               lp_waddr = a_ff;
            end
         end
         ST_PUSH: begin
            h_op  = HOP_PUSH;
            h_key = a_ff;
         end
         ST_OUT: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         node_count_ff <= NODE_COUNT_RESET;
         load_count_ff <= '0;
         edge_count_ff <= '0;
         draining_ff   <= 1'b0;
         pv_ff         <= 1'b0;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en && !draining_ff && load_count_ff == '0) begin
            node_count_ff <= csr_wr_data;
         end
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + NW'(1);
         if (state_ff == ST_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         pv_ff <= (state_ff == ST_FILL) && scan_issue;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && req_cmd == CMD_LOAD && !load_bad_phase && !node_bad) begin
                  load_count_ff <= load_count_ff + CW'(1);
               end
               if (accept && req_cmd == CMD_EDGE && !draining_ff && edge_ready) begin
                  draining_ff   <= 1'b1;
                  edge_count_ff <= '0;
               end
            end
            ST_CODE: begin
               if (!edge_more) begin
                  load_count_ff <= '0;
                  edge_count_ff <= '0;
                  draining_ff   <= 1'b0;
               end
            end
            ST_EDGE: edge_count_ff <= edge_count_ff + CW'(1);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE) begin
         scan_ff     <= '0;
         h_first_ff  <= '0;
         h_second_ff <= '0;
         h_last_ff   <= 1'b0;
         h_err_ff    <= (req_cmd == CMD_LOAD && !load_bad_phase) ? ERR_RANGE : ERR_PHASE;
      end
      if (state_ff == ST_FILL && scan_issue) scan_ff <= scan_ff + CW'(1);
      pa_ff <= scan_ff[NW-1:0];
      if (state_ff == ST_POS) a_ff <= cs_rdata;
      if (state_ff == ST_CODE && !edge_more) begin
         h_first_ff  <= FIELD_W'(min0_inc);
         h_second_ff <= FIELD_W'(min1_inc);
         h_last_ff   <= 1'b1;
         h_err_ff    <= ERR_NONE;
      end
      if (state_ff == ST_EDGE) begin
         h_first_ff  <= FIELD_W'(a_inc);
         h_second_ff <= FIELD_W'(min0_inc);
         h_last_ff   <= 1'b0;
         h_err_ff    <= ERR_NONE;
      end
      if (state_ff == ST_OUT && out_free) begin
         rsp_first_ff  <= h_first_ff;
         rsp_second_ff <= h_second_ff;
         rsp_last_ff   <= h_last_ff;
         rsp_err_ff    <= h_err_ff;
      end
   end

   psd_ram #(.WIDTH(LPW), .DEPTH(MAX_NODES)) u_last_pos (
      .clock   (clock),
      .wr_en   (lp_we),
      .wr_addr (lp_waddr),
      .wr_data (lp_wdata),
      .rd_addr (lp_raddr),
      .rd_data (lp_rdata)
   );

   psd_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_code (
      .clock   (clock),
      .wr_en   (cs_we),
      .wr_addr (load_count_ff[NW-1:0]),
      .wr_data (node_addr),
      .rd_addr (edge_count_ff[NW-1:0]),
      .rd_data (cs_rdata)
   );

   psd_heap #(.KEY_W(NW), .DEPTH(MAX_NODES)) u_heap (
      .clock (clock),
      .reset (reset),
      .op    (h_op),
      .key   (h_key),
      .min0  (min0),
      .min1  (min1)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_first_node  = rsp_first_ff;
   assign rsp_second_node = rsp_second_ff;
   assign rsp_last_edge   = rsp_last_ff;
   assign rsp_error       = rsp_err_ff;
endmodule
`default_nettype wire
